>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/jls_pkg.sv
// shared types and constants for the jacobi laplace sweep block
// no dependencies
`timescale 1ns / 1ps

package jls_pkg;

  localparam int DATA_W     = 32;
  localparam int MAX_COLS   = 1024;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_HALO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_HALO = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  // one line buffer column: row r-2 and row r-1 cells
  typedef struct packed {
    data_t older;
    data_t newer;
  } line_entry_t;

  // everything one accepted cell needs for its results
  typedef struct packed {
    data_t cur;
    data_t halo;
    data_t above;
    data_t centre;
    data_t left;
    data_t right;
    logic  row_top;
    logic  row_mid;
    logic  row_last;
    logic  col_border;
    logic  col_last;
    logic  use_top;
    logic  use_bottom;
  } item_ctx_t;

  typedef struct packed {
    data_t value;
    logic  last;
  } out_entry_t;

  // results handed from the stencil stage to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    out_entry_t e0;
    out_entry_t e1;
  } push_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

>>> hw/rtl/jls_line_buf.sv
// line buffer memory holding the two previous grid rows per column
// depends on jls_pkg
`timescale 1ns / 1ps

module jls_line_buf (
  input  logic                      clk,
  input  logic                      we,
  input  logic [jls_pkg::COL_W-1:0] waddr,
  input  jls_pkg::line_entry_t      wdata,
  input  logic                      re,
  input  logic [jls_pkg::COL_W-1:0] raddr,
  output jls_pkg::line_entry_t      rdata
);
  import jls_pkg::*;

  line_entry_t mem [MAX_COLS];
  line_entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, new data forwarded on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/jls_stencil.sv
// stencil stage: registers one cell with its neighbours and forms its results
// depends on jls_pkg
`timescale 1ns / 1ps

module jls_stencil (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  jls_pkg::item_ctx_t  ctx,
  output jls_pkg::push_t      push
);
  import jls_pkg::*;

  logic                 s1_valid_r;
  item_ctx_t            ctx_r;
  logic signed [DATA_W+1:0] sum;
  data_t                quarter;
  out_entry_t           first;
  out_entry_t           second;
  logic                 has_first;
  logic                 has_second;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= load;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      ctx_r <= ctx;
    end
  end

  // four neighbour sum, floor of a quarter by dropping two bits
  assign sum = {{2{ctx_r.above[DATA_W-1]}}, ctx_r.above}
             + {{2{ctx_r.cur[DATA_W-1]}}, ctx_r.cur}
             + {{2{ctx_r.left[DATA_W-1]}}, ctx_r.left}
             + {{2{ctx_r.right[DATA_W-1]}}, ctx_r.right};
  assign quarter = sum[DATA_W+1:2];

  // result for row 0 or for the row above the current one
  always_comb begin
    has_first  = ctx_r.row_top | ctx_r.row_mid;
    first.last = 1'b0;
    if (ctx_r.row_top) begin
      first.value = ctx_r.use_top ? ctx_r.halo : ctx_r.cur;
    end else if (ctx_r.col_border) begin
      first.value = ctx_r.centre;
    end else begin
      first.value = quarter;
    end
  end

  // extra result on the last row
  always_comb begin
    has_second   = ctx_r.row_last;
    second.value = ctx_r.use_bottom ? ctx_r.halo : ctx_r.cur;
    second.last  = ctx_r.col_last;
  end

  // pack results in output order
  always_comb begin
    push.cnt = s1_valid_r ? ({1'b0, has_first} + {1'b0, has_second}) : 2'd0;
    push.e0  = has_first ? first : second;
    push.e1  = second;
  end

endmodule

>>> hw/rtl/jls_out_fifo.sv
// four entry output queue, takes up to two results a cycle, gives one
// depends on jls_pkg
`timescale 1ns / 1ps

module jls_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jls_pkg::push_t        push,
  input  logic                  pop,
  output logic                  valid,
  output jls_pkg::out_entry_t   head,
  output jls_pkg::fifo_stat_t   stat
);
  import jls_pkg::*;

  out_entry_t       buf_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] wp_nxt;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W-1:0] rp_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // pointer and fill arithmetic
  always_comb begin
    wp_nxt    = wp_r + PTR_W'(push.cnt);
    rp_nxt    = pop ? (rp_r + PTR_W'(1)) : rp_r;
    count_nxt = count_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      buf_r[wp_r] <= push.e0;
    end
    if (push.cnt == 2'd2) begin
      buf_r[wp_r + PTR_W'(1)] <= push.e1;
    end
  end

  assign valid      = (count_r != '0);
  assign head       = buf_r[rp_r];
  assign stat.count = count_r;

endmodule

>>> hw/rtl/jacobi_laplace_sweep.sv
// top level of the jacobi laplace sweep block
// depends on jls_pkg, jls_line_buf, jls_stencil, jls_out_fifo, assert_macros.svh
//
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    in_cell_value, in_halo_value
// out_      output     out_valid / out_stall  out_result_value, out_last_cell
// cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// one cell is taken per cycle while in_stall is low.
// cells of the last row give two results each, so there the rate is set by the
// output queue draining one result a cycle.
// the line buffer is one 1024 x 64 memory, one write and one prefetch read a cell.
// synchronous reset; no clearing pass, the line buffer is written before use.
// in_stall rises when the four entry output queue cannot take another cell.
`timescale 1ns / 1ps

module jacobi_laplace_sweep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  jls_pkg::data_t                in_cell_value,
  input  jls_pkg::data_t                in_halo_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output jls_pkg::data_t                out_result_value,
  output logic                          out_last_cell,
  input  logic                          cfg_we,
  input  logic [jls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jls_pkg::CFG_W-1:0]     cfg_wdata
);
  import jls_pkg::*;

  `include "assert_macros.svh"

  logic [ROW_W-1:0] m1_r;
  logic [ROW_W-1:0] m1_nxt;
  logic [COL_W-1:0] n1_r;
  logic [COL_W-1:0] n1_nxt;
  logic             top_r;
  logic             top_nxt;
  logic             bot_r;
  logic             bot_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  data_t            saved_r;
  line_entry_t      win0_r;
  line_entry_t      win1_r;
  line_entry_t      rdata;
  line_entry_t      wdata;
  logic [COL_W-1:0] raddr;
  logic [COL_W:0]   ahead;
  logic [COL_W:0]   ncols;
  logic             in_fire;
  logic             out_fire;
  logic             last_row;
  logic             last_col;
  item_ctx_t        ctx;
  push_t            push;
  out_entry_t       head;
  fifo_stat_t       fstat;
  logic [CNT_W-1:0] backlog;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign last_row = (row_r == m1_r);
  assign last_col = (col_r == n1_r);

  // config writes, dimensions clamped and held as last index; columns use the low 11 data bits
  always_comb begin
    m1_nxt  = m1_r;
    n1_nxt  = n1_r;
    top_nxt = top_r;
    bot_nxt = bot_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: begin
          if (cfg_wdata < CFG_W'(3)) begin
            m1_nxt = ROW_W'(2);
          end else if (cfg_wdata > CFG_W'(4096)) begin
            m1_nxt = ROW_W'(4095);
          end else begin
            m1_nxt = ROW_W'(cfg_wdata - CFG_W'(1));
          end
        end
        CFG_COLS: begin
          if (cfg_wdata[COL_W:0] < 11'd3) begin
            n1_nxt = COL_W'(2);
          end else if (cfg_wdata[COL_W:0] > 11'd1024) begin
            n1_nxt = COL_W'(1023);
          end else begin
            n1_nxt = COL_W'(cfg_wdata[COL_W:0] - 11'd1);
          end
        end
        CFG_TOP_HALO:    top_nxt = cfg_wdata[0];
        CFG_BOTTOM_HALO: bot_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r  <= ROW_W'(2);
      n1_r  <= COL_W'(2);
      top_r <= 1'b0;
      bot_r <= 1'b0;
    end else begin
      m1_r  <= m1_nxt;
      n1_r  <= n1_nxt;
      top_r <= top_nxt;
      bot_r <= bot_nxt;
    end
  end

  // raster position of the next cell, restarted by any config write
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_we) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : (row_r + ROW_W'(1));
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      saved_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_we) begin
        saved_r <= '0;
      end else if (in_fire) begin
        saved_r <= win0_r.newer;
      end
    end
  end

  // prefetch three columns ahead, wrapping at the row end
  always_comb begin
    ahead = {1'b0, col_r} + (COL_W+1)'(3);
    ncols = {1'b0, n1_r} + (COL_W+1)'(1);
    if (ahead >= ncols) begin
      raddr = COL_W'(ahead - ncols);
    end else begin
      raddr = ahead[COL_W-1:0];
    end
  end

  assign wdata.older = win0_r.newer;
  assign wdata.newer = in_cell_value;

  jls_line_buf u_line_buf (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_r),
    .wdata (wdata),
    .re    (in_fire),
    .raddr (raddr),
    .rdata (rdata)
  );

  // window over the current and next column
  always_ff @(posedge clk) begin
    if (in_fire) begin
      win0_r <= win1_r;
      win1_r <= rdata;
    end
  end

  // neighbourhood of the accepted cell
  always_comb begin
    ctx.cur        = in_cell_value;
    ctx.halo       = in_halo_value;
    ctx.above      = win0_r.older;
    ctx.centre     = win0_r.newer;
    ctx.left       = saved_r;
    ctx.right      = win1_r.newer;
    ctx.row_top    = (row_r == '0);
    ctx.row_mid    = (row_r[ROW_W-1:1] != '0);
    ctx.row_last   = last_row;
    ctx.col_border = (col_r == '0) || last_col;
    ctx.col_last   = last_col;
    ctx.use_top    = top_r;
    ctx.use_bottom = bot_r;
  end

  jls_stencil u_stencil (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_fire),
    .ctx   (ctx),
    .push  (push)
  );

  jls_out_fifo u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_fire),
    .valid (out_valid),
    .head  (head),
    .stat  (fstat)
  );

  // hold off input unless queue has room for the stage and a new cell
  assign backlog  = fstat.count + CNT_W'(push.cnt);
  assign in_stall = (backlog > CNT_W'(FIFO_DEPTH - 2));

  assign out_result_value = head.value;
  assign out_last_cell    = head.last;

  // checks
  `ASSERT_ALWAYS(a_fifo_bound, fstat.count <= CNT_W'(FIFO_DEPTH), "output queue overflow")
  `ASSERT_NEXT(a_final_pair, in_fire && last_row && last_col, push.cnt == 2'd2, "final cell lost a result")
  `ASSERT_NEXT(a_row_one_quiet, in_fire && (row_r == ROW_W'(1)), push.cnt == 2'd0, "row one gave a result")
  `ASSERT_NEXT(a_top_single, in_fire && (row_r == '0), push.cnt == 2'd1 && !push.e0.last, "row zero result count wrong")

endmodule
